@@ hw/rtl/u8u16_pkg.sv @@
// Package for the UTF-8 to UTF-16 decoder: result item type, decode constants
// and the helper that turns a finished code point into UTF-16 units.
// Depends on nothing; used by the decode stage, output queue and top level.
`timescale 1ns / 1ps

package u8u16_pkg;

	// Code point limits and UTF-16 constants.
	localparam logic [30:0] MAX_CODE_POINT = 31'h10FFFF;
	localparam logic [30:0] SURR_START     = 31'h00D800;
	localparam logic [30:0] SURR_END       = 31'h00DFFF;
	localparam logic [30:0] PLANE1_START   = 31'h010000;
	localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
	localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
	localparam logic [15:0] REPLACEMENT    = 16'hFFFD;

	// Lead byte class boundaries.
	localparam logic [7:0] LEAD_MIN   = 8'hC2;
	localparam logic [7:0] LEAD_BAD   = 8'hFE;
	localparam logic [7:0] ASCII_END  = 8'h80;
	localparam logic [7:0] LEAD3_MIN  = 8'hE0;
	localparam logic [7:0] LEAD4_MIN  = 8'hF0;
	localparam logic [7:0] LEAD5_MIN  = 8'hF8;
	localparam logic [7:0] LEAD6_MIN  = 8'hFC;

	// Smallest first continuation byte allowed when the lead byte adds no bits.
	localparam logic [7:0] LIMIT3 = 8'hA0;
	localparam logic [7:0] LIMIT4 = 8'h90;
	localparam logic [7:0] LIMIT5 = 8'h88;
	localparam logic [7:0] LIMIT6 = 8'h84;

	// Output queue geometry.
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// One result item.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        replaced;
		logic        last_unit;
		logic        buffer_ok;
	} entry_t;

	// What one decode step hands to the output queue.
	typedef struct packed {
		logic [1:0] count;
		entry_t     e0;
		entry_t     e1;
	} step_t;

	// Units for a finished code point.
	typedef struct packed {
		logic [1:0]  count;
		logic        rep;
		logic [15:0] u0;
		logic [15:0] u1;
	} units_t;

	function automatic units_t to_units(input logic [30:0] cp, input logic bad);
		units_t      r;
		logic [20:0] v;
		v = cp[20:0] - PLANE1_START[20:0];
		r.count = 2'd1;
		r.rep   = 1'b0;
		r.u0    = cp[15:0];
		r.u1    = 16'h0000;
		if (bad || cp > MAX_CODE_POINT || (cp >= SURR_START && cp <= SURR_END)) begin
			r.u0  = REPLACEMENT;
			r.rep = 1'b1;
		end else if (cp >= PLANE1_START) begin
			r.count = 2'd2;
			r.u0    = HIGH_SURR_BASE + {6'd0, v[19:10]};
			r.u1    = LOW_SURR_BASE + {6'd0, v[9:0]};
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/u8u16_decode.sv @@
// Decode stage: holds the sequence state and turns one registered byte
// combinationally into zero, one or two result items.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  logic [7:0]        data_byte,
	input  logic              end_of_buffer,
	output u8u16_pkg::step_t  step
);
	import u8u16_pkg::*;

	logic [2:0]  bytes_left_q, bytes_left_d;
	logic [30:0] acc_q, acc_d;
	logic        seq_bad_q, seq_bad_d;
	logic        first_q, first_d;
	logic [7:0]  limit_q, limit_d;
	logic        buf_bad_q, buf_bad_d;

	logic [1:0]  n;
	logic        rep;
	logic [15:0] u0, u1;
	logic        bad_now;
	logic [30:0] acc_new;
	logic [2:0]  left_new;
	logic        buf_bad_eff;
	units_t      fin;

	// Next sequence state and the units this byte produces.
	always_comb begin
		bytes_left_d = bytes_left_q;
		acc_d        = acc_q;
		seq_bad_d    = seq_bad_q;
		first_d      = first_q;
		limit_d      = limit_q;
		n            = 2'd0;
		rep          = 1'b0;
		u0           = 16'h0000;
		u1           = 16'h0000;
		bad_now  = seq_bad_q | (first_q && (data_byte < limit_q) && (acc_q == 31'd0));
		acc_new  = {acc_q[24:0], data_byte[5:0]};
		left_new = bytes_left_q - 3'd1;
		fin      = to_units(acc_new, bad_now);
		if (bytes_left_q == 3'd0) begin
			if (data_byte < ASCII_END) begin
				n  = 2'd1;
				u0 = {8'h00, data_byte};
			end else if (data_byte < LEAD_MIN || data_byte >= LEAD_BAD) begin
				n   = 2'd1;
				rep = 1'b1;
				u0  = REPLACEMENT;
			end else begin
				if (data_byte < LEAD3_MIN) begin
					bytes_left_d = 3'd1;
					acc_d        = {26'd0, data_byte[4:0]};
					limit_d      = 8'h00;
				end else if (data_byte < LEAD4_MIN) begin
					bytes_left_d = 3'd2;
					acc_d        = {27'd0, data_byte[3:0]};
					limit_d      = LIMIT3;
				end else if (data_byte < LEAD5_MIN) begin
					bytes_left_d = 3'd3;
					acc_d        = {28'd0, data_byte[2:0]};
					limit_d      = LIMIT4;
				end else if (data_byte < LEAD6_MIN) begin
					bytes_left_d = 3'd4;
					acc_d        = {29'd0, data_byte[1:0]};
					limit_d      = LIMIT5;
				end else begin
					bytes_left_d = 3'd5;
					acc_d        = {30'd0, data_byte[0]};
					limit_d      = LIMIT6;
				end
				seq_bad_d = 1'b0;
				first_d   = 1'b1;
				if (end_of_buffer) begin
					bytes_left_d = 3'd0;
					acc_d        = 31'd0;
					first_d      = 1'b0;
					limit_d      = 8'h00;
					n            = 2'd1;
					rep          = 1'b1;
					u0           = REPLACEMENT;
				end
			end
		end else if (data_byte == 8'h00) begin
			// A zero continuation byte ends the sequence as invalid.
			bytes_left_d = 3'd0;
			acc_d        = 31'd0;
			seq_bad_d    = 1'b0;
			first_d      = 1'b0;
			limit_d      = 8'h00;
			n            = 2'd1;
			rep          = 1'b1;
			u0           = REPLACEMENT;
		end else if (left_new == 3'd0 || end_of_buffer) begin
			// Sequence complete, or cut off by the end of the buffer.
			bytes_left_d = 3'd0;
			acc_d        = 31'd0;
			seq_bad_d    = 1'b0;
			first_d      = 1'b0;
			limit_d      = 8'h00;
			n            = 2'd1;
			rep          = 1'b1;
			u0           = REPLACEMENT;
			if (left_new == 3'd0) begin
				n   = fin.count;
				rep = fin.rep;
				u0  = fin.u0;
				u1  = fin.u1;
			end
		end else begin
			bytes_left_d = left_new;
			acc_d        = acc_new;
			seq_bad_d    = bad_now;
			first_d      = 1'b0;
		end
	end

	// Result items with end-of-buffer flags.
	always_comb begin
		buf_bad_eff = buf_bad_q | rep;
		buf_bad_d   = end_of_buffer ? 1'b0 : buf_bad_eff;
		step.count  = valid ? n : 2'd0;
		step.e0.code_unit = u0;
		step.e0.replaced  = rep;
		step.e0.last_unit = end_of_buffer && (n == 2'd1);
		step.e0.buffer_ok = end_of_buffer && (n == 2'd1) && !buf_bad_eff;
		step.e1.code_unit = u1;
		step.e1.replaced  = rep;
		step.e1.last_unit = end_of_buffer;
		step.e1.buffer_ok = end_of_buffer && !buf_bad_eff;
	end

	// Sequence state registers advance once per registered byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 3'd0;
			acc_q        <= 31'd0;
			seq_bad_q    <= 1'b0;
			first_q      <= 1'b0;
			limit_q      <= 8'h00;
			buf_bad_q    <= 1'b0;
		end else if (valid) begin
			bytes_left_q <= bytes_left_d;
			acc_q        <= acc_d;
			seq_bad_q    <= seq_bad_d;
			first_q      <= first_d;
			limit_q      <= limit_d;
			buf_bad_q    <= buf_bad_d;
		end
	end

endmodule

@@ hw/rtl/u8u16_outq.sv @@
// Output queue: a small register queue that takes up to two result items per
// cycle from the decode stage and hands out one per cycle while m_tready is high.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_outq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  u8u16_pkg::step_t              step,
	output logic [u8u16_pkg::OQ_CW-1:0]   level,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output u8u16_pkg::entry_t             m_entry
);
	import u8u16_pkg::*;

	entry_t             mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0]   wptr_q, rptr_q;
	logic [OQ_CW-1:0]   count_q;
	logic               pop;
	logic [OQ_AW-1:0]   wptr_nxt;

	assign pop      = m_tvalid && m_tready;
	assign wptr_nxt = wptr_q + OQ_AW'(1);
	assign m_tvalid = (count_q != '0);
	assign m_entry  = mem_q[rptr_q];
	assign level    = count_q;

	// Entry storage; a surrogate pair lands in two consecutive slots.
	always_ff @(posedge clk) begin
		if (step.count != 2'd0) begin
			mem_q[wptr_q] <= step.e0;
		end
		if (step.count == 2'd2) begin
			mem_q[wptr_nxt] <= step.e1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + OQ_AW'(step.count);
			rptr_q  <= rptr_q + OQ_AW'(pop);
			count_q <= count_q + OQ_CW'(step.count) - OQ_CW'(pop);
		end
	end

endmodule

@@ hw/rtl/utf8_to_utf16_decoder.sv @@
// Top level of the UTF-8 to UTF-16 decoder: input register, decode stage and
// output queue. Depends on u8u16_pkg, u8u16_decode and u8u16_outq.
`timescale 1ns / 1ps

// The decoder takes one UTF-8 byte per cycle on the slave side while s_tready
// is high and produces UTF-16 code units on the master side. A byte is
// registered when accepted and decoded in the following cycle; its units enter
// the four-entry output queue at the end of that cycle and are offered on the
// master side from there. Bytes go in back to back at one per cycle while the
// queue has room; the master side moves one unit per cycle while m_tready is
// high, so a surrogate pair yields two units and the input then waits on queue
// space. s_tready depends only on the queue fill and on the units that the
// decode stage is producing, never on m_tready directly. Every end-of-buffer
// byte yields at least one unit, and the last unit of the buffer carries tlast
// together with the buffer-ok flag.
module utf8_to_utf16_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_buffer
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] code_unit
	output logic [1:0]  m_tuser,   // [0] replaced, [1] buffer_ok
	output logic        m_tlast    // last_unit
);
	import u8u16_pkg::*;

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               eob_s1;
	step_t              step;
	logic [OQ_CW-1:0]   level;
	entry_t             head;
	logic [OQ_CW+1:0]   need;

	// Accept a byte only if the queue can still take two units from it after
	// the units of the byte now in decode are written.
	assign need     = (OQ_CW+2)'(level) + (OQ_CW+2)'(step.count) + (OQ_CW+2)'(2);
	assign s_tready = (need <= (OQ_CW+2)'(OQ_DEPTH));

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eob_s1  <= s_tlast;
		end
	end

	u8u16_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid         (valid_s1),
		.data_byte     (byte_s1),
		.end_of_buffer (eob_s1),
		.step          (step)
	);

	u8u16_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.level    (level),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_entry  (head)
	);

	// Master side payload.
	assign m_tdata = head.code_unit;
	assign m_tuser = {head.buffer_ok, head.replaced};
	assign m_tlast = head.last_unit;

endmodule

@@ hw/rtl/u8u16_checker.sv @@
// Port checker for the UTF-8 to UTF-16 decoder, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module u8u16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// A waiting unit stays offered and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output item changed while stalled");

	// A replaced unit is always the replacement character.
	a_rep_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 16'hFFFD)
		else $error("replaced item is not U+FFFD");

	// Buffer-ok is only shown on the last unit of a buffer.
	a_ok_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("buffer_ok set on a non-final item");

	// A buffer whose last unit is a replacement cannot be ok.
	a_rep_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tuser[1])
		else $error("buffer_ok set on a replaced item");

endmodule

bind utf8_to_utf16_decoder u8u16_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
